>>> sv/lse_pkg.sv
// shared types and constants for the led strip effect generator
// no dependencies

package lse_pkg;

   localparam int unsigned LED_TOTAL = 10;

   typedef enum logic [1:0] {
      CSR_EFFECT     = 2'd0,
      CSR_COLOR      = 2'd1,
      CSR_BRIGHTNESS = 2'd2
   } csr_index_type;

   localparam logic [2:0] FX_DOT    = 3'd1;
   localparam logic [2:0] FX_STROBE = 3'd3;
   localparam logic [2:0] FX_SOS    = 3'd4;
   localparam logic [2:0] FX_HAZARD = 3'd5;
   localparam logic [2:0] FX_POLICE = 3'd6;

   localparam logic [23:0] COLOR_BLACK  = 24'h000000;
   localparam logic [23:0] COLOR_WHITE  = 24'hFFFFFF;
   localparam logic [23:0] COLOR_SOS    = 24'hFF5000;
   localparam logic [23:0] COLOR_HAZARD = 24'hFF3C00;
   localparam logic [23:0] COLOR_BLUE   = 24'h0000FF;
   localparam logic [23:0] COLOR_RED    = 24'hFF0000;

   localparam logic [31:0] DOT_WAIT     = 32'd50;
   localparam logic [31:0] STROBE_IDLE  = 32'd5000;
   localparam logic [31:0] STROBE_STEP  = 32'd80;
   localparam logic [4:0]  STROBE_STEPS = 5'd18;
   localparam logic [31:0] SOS_DARK     = 32'd200;
   localparam logic [31:0] HAZARD_WAIT  = 32'd500;
   localparam logic [31:0] POLICE_PAUSE = 32'd300;
   localparam logic [31:0] POLICE_BLINK = 32'd100;
   localparam logic [3:0]  SOS_STEPS    = 4'd15;

   function automatic logic [31:0] sos_duration(input logic [3:0] step);
      logic [31:0] d;
      d = ((step >= 4'd6) && (step <= 4'd11)) ? 32'd600 : 32'd200;
      return d;
   endfunction

   // frame update ordered by the front part, carried out by the back part
   typedef enum logic [2:0] {
      OP_FILL,
      OP_DOT,
      OP_HAZARD,
      OP_POLICE_L,
      OP_POLICE_R
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [23:0] color;
      logic [3:0]  dot_pos;
      logic        bright;
   } cmd_type;

   function automatic logic [7:0] fade(input logic [7:0] c);
      logic [15:0] p;
      p = {8'd0, c} * 16'd206;
      return p[15:8];
   endfunction

endpackage

>>> sv/lse_front.sv
// front part: per-effect timers, decides whether a tick writes the frame
// depends on lse_pkg

module lse_front import lse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic [2:0]  effect_sel,
   input  logic [23:0] base_color,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   logic        full_ff, full_in;
   logic [3:0]  dpos_ff, dpos_in;
   logic [31:0] dtime_ff, dtime_in;
   logic [31:0] stime_ff, stime_in;
   logic [4:0]  scount_ff, scount_in;
   logic        sact_ff, sact_in;
   logic [31:0] otime_ff, otime_in;
   logic [3:0]  ostep_ff, ostep_in;
   logic        olit_ff, olit_in;
   logic [31:0] htime_ff, htime_in;
   logic        hlit_ff, hlit_in;
   logic [31:0] ptime_ff, ptime_in;
   logic [1:0]  pcount_ff, pcount_in;
   logic        pleft_ff, pleft_in;
   logic        plit_ff, plit_in;

   logic        wrote;
   cmd_type     c;
   logic [31:0] dd, sd, od, hd, pd;
   logic [3:0]  ostep_cur;
   logic [1:0]  pc;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid && wrote;

   always_comb begin
      dd = req_now_ms - dtime_ff;
      sd = req_now_ms - stime_ff;
      od = req_now_ms - otime_ff;
      hd = req_now_ms - htime_ff;
      pd = req_now_ms - ptime_ff;
      full_in = full_ff; dpos_in = dpos_ff; dtime_in = dtime_ff;
      stime_in = stime_ff; scount_in = scount_ff; sact_in = sact_ff;
      otime_in = otime_ff; ostep_in = ostep_ff; olit_in = olit_ff;
      htime_in = htime_ff; hlit_in = hlit_ff;
      ptime_in = ptime_ff; pcount_in = pcount_ff; pleft_in = pleft_ff;
      plit_in = plit_ff;
      ostep_cur = (ostep_ff >= SOS_STEPS) ? 4'd0 : ostep_ff;
      pc = pcount_ff;
      wrote = 1'b1;
      c.op = OP_FILL; c.color = base_color; c.dot_pos = dpos_ff; c.bright = full_ff;
      case (effect_sel)
         FX_DOT: begin
            if (dd <= DOT_WAIT) begin
               wrote = 1'b0;
            end else begin
               dtime_in = req_now_ms;
               c.op = OP_DOT;
               c.dot_pos = (dpos_ff >= 4'd10) ? 4'd0 : dpos_ff;
               dpos_in = (c.dot_pos == 4'd9) ? 4'd0 : c.dot_pos + 4'd1;
            end
         end
         FX_STROBE: begin
            if (!sact_ff) begin
               if (sd > STROBE_IDLE) begin
                  sact_in = 1'b1; scount_in = 5'd0;
               end
               c.color = COLOR_BLACK;
            end else if (sd <= STROBE_STEP) begin
               wrote = 1'b0;
            end else begin
               if (!scount_ff[0]) begin
                  c.color = COLOR_WHITE; full_in = 1'b1; c.bright = 1'b1;
               end else begin
                  c.color = COLOR_BLACK;
               end
               scount_in = scount_ff + 5'd1;
               stime_in = req_now_ms;
               if (scount_in >= STROBE_STEPS) sact_in = 1'b0;
            end
         end
         FX_SOS: begin
            ostep_in = ostep_cur;
            if (od < (olit_ff ? sos_duration(ostep_cur) : SOS_DARK)) begin
               wrote = 1'b0;
            end else begin
               otime_in = req_now_ms;
               olit_in = !olit_ff;
               if (!olit_ff) begin
                  c.color = COLOR_SOS;
               end else begin
                  c.color = COLOR_BLACK;
                  ostep_in = (ostep_cur == 4'd14) ? 4'd0 : ostep_cur + 4'd1;
               end
            end
         end
         FX_HAZARD: begin
            if (hd <= HAZARD_WAIT) begin
               wrote = 1'b0;
            end else begin
               htime_in = req_now_ms;
               hlit_in = !hlit_ff;
               c.op = OP_HAZARD;
               c.color = hlit_in ? COLOR_HAZARD : COLOR_BLACK;
            end
         end
         FX_POLICE: begin
            if (pd < ((pcount_ff == 2'd0 && !plit_ff) ? POLICE_PAUSE : POLICE_BLINK)) begin
               wrote = 1'b0;
            end else begin
               ptime_in = req_now_ms;
               c.color = COLOR_BLACK;
               if (plit_ff) begin
                  c.op = pleft_ff ? OP_POLICE_L : OP_POLICE_R;
                  pc = pcount_ff + 2'd1;
               end
               plit_in = !plit_ff;
               pcount_in = pc;
               if (plit_ff && pc == 2'd3) begin
                  pleft_in = !pleft_ff; pcount_in = 2'd0;
               end
            end
         end
         default: begin
         end
      endcase
      cmd = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0; dpos_ff <= '0; dtime_ff <= '0; stime_ff <= '0;
         scount_ff <= '0; sact_ff <= 1'b0; otime_ff <= '0; ostep_ff <= '0;
         olit_ff <= 1'b0; htime_ff <= '0; hlit_ff <= 1'b0; ptime_ff <= '0;
         pcount_ff <= '0; pleft_ff <= 1'b1; plit_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         full_ff <= full_in; dpos_ff <= dpos_in; dtime_ff <= dtime_in;
         stime_ff <= stime_in; scount_ff <= scount_in; sact_ff <= sact_in;
         otime_ff <= otime_in; ostep_ff <= ostep_in; olit_ff <= olit_in;
         htime_ff <= htime_in; hlit_ff <= hlit_in; ptime_ff <= ptime_in;
         pcount_ff <= pcount_in; pleft_ff <= pleft_in; plit_ff <= plit_in;
      end
   end

endmodule

>>> sv/lse_queue.sv
// two-entry command queue between front and back
// depends on lse_pkg

module lse_queue import lse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_cmd   = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) mem_ff[wp_ff] <= in_cmd;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (in_valid && in_ready) wp_ff <= !wp_ff;
         if (out_valid && out_ready) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
      end
   end

endmodule

>>> sv/lse_back.sv
// back part: applies a command to the frame store and streams ten leds
// depends on lse_pkg

module lse_back import lse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   input  logic [7:0]  base_brightness,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_led_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_brightness,
   output logic        rsp_last
);

   typedef enum logic {ST_IDLE, ST_SEND} state_type;

   state_type   state_ff;
   logic [23:0] frame_ff [LED_TOTAL];
   logic [3:0]  idx_ff;
   logic        full_ff;
   logic [23:0] nxt [LED_TOTAL];
   logic [23:0] px;

   assign cmd_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_SEND;
   assign px = frame_ff[idx_ff];
   assign rsp_led_index = idx_ff;
   assign rsp_red = px[23:16];
   assign rsp_green = px[15:8];
   assign rsp_blue = px[7:0];
   assign rsp_brightness = full_ff ? 8'd255 : base_brightness;
   assign rsp_last = idx_ff == 4'(LED_TOTAL - 1);

   always_comb begin
      for (int i = 0; i < LED_TOTAL; i++) begin
         case (cmd.op)
            OP_DOT: nxt[i] = (4'(i) == cmd.dot_pos) ? cmd.color :
               {fade(frame_ff[i][23:16]), fade(frame_ff[i][15:8]), fade(frame_ff[i][7:0])};
            OP_HAZARD: nxt[i] = (i == 0 || i == 4 || i == 5 || i == 9) ? cmd.color : COLOR_BLACK;
            OP_POLICE_L: nxt[i] = (i <= 1 || i >= 7) ? COLOR_BLUE : COLOR_BLACK;
            OP_POLICE_R: nxt[i] = (i >= 2 && i <= 6) ? COLOR_RED : COLOR_BLACK;
            default: nxt[i] = cmd.color;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; idx_ff <= '0; full_ff <= 1'b0;
         for (int i = 0; i < LED_TOTAL; i++) frame_ff[i] <= COLOR_BLACK;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  for (int i = 0; i < LED_TOTAL; i++) frame_ff[i] <= nxt[i];
                  full_ff <= cmd.bright;
                  idx_ff <= '0;
                  state_ff <= ST_SEND;
               end
            end
            ST_SEND: begin
               if (rsp_ready) begin
                  if (rsp_last) state_ff <= ST_IDLE;
                  else idx_ff <= idx_ff + 4'd1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> sv/led_strip_effect_generator_top.sv
// led strip effect generator: one millisecond tick in, zero or ten leds out
// first led of a frame is offered once the back part is idle and has taken its command from the queue
// into the frame store; a frame is ten led items, and the back part goes idle after the last is taken
// the queue holds two further commands, so ticks are taken while a frame is still streaming
// ticks that write no frame are taken at one per cycle while the queue has room
// reset (synchronous) clears frame to black, timers to zero, brightness 255
// depends on lse_pkg, lse_front, lse_queue, lse_back

module led_strip_effect_generator_top import lse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_led_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_brightness,
   output logic        rsp_last
);

   logic [2:0]  effect_ff;
   logic [23:0] color_ff;
   logic [7:0]  bright_ff;
   logic        fv, fr, qv, qr;
   cmd_type     fc, qc;

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_ff <= '0; color_ff <= '0; bright_ff <= 8'd255;
      end else if (csr_write) begin
         case (csr_index)
            CSR_EFFECT:     effect_ff <= csr_data[2:0];
            CSR_COLOR:      color_ff <= csr_data;
            CSR_BRIGHTNESS: bright_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   lse_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_now_ms,
      .effect_sel(effect_ff), .base_color(color_ff),
      .cmd_valid(fv), .cmd_ready(fr), .cmd(fc)
   );

   lse_queue u_queue (
      .clock, .reset, .in_valid(fv), .in_ready(fr), .in_cmd(fc),
      .out_valid(qv), .out_ready(qr), .out_cmd(qc)
   );

   lse_back u_back (
      .clock, .reset, .cmd_valid(qv), .cmd_ready(qr), .cmd(qc),
      .base_brightness(bright_ff), .rsp_valid, .rsp_ready, .rsp_led_index,
      .rsp_red, .rsp_green, .rsp_blue, .rsp_brightness, .rsp_last
   );

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_led_index == 4'(LED_TOTAL - 1))
      else $error("last flag off the final led");
   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid &&
      rsp_led_index == $past(rsp_led_index) + 4'd1)
      else $error("led index skipped");
   a_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_led_index == 4'd0)
      else $error("frame not started at led zero");

endmodule

>>> tb/tb_led_strip_effect_generator_top.sv
// testbench for the led strip effect generator: directed table then random ticks
// predicts each frame with its own effect model and checks every led item in order
// depends on lse_pkg and led_strip_effect_generator_top

module tb_led_strip_effect_generator_top;
   import lse_pkg::*;

   typedef struct packed {
      logic [3:0] idx;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] bri;
      logic       lst;
   } led_item_t;

   typedef struct {
      logic [31:0] now;
      bit          known;
      logic [23:0] rgb;
      logic [7:0]  bri;
   } tick_row_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_now_ms = 0;
   logic        csr_write = 0;
   logic [1:0]  csr_index = CSR_EFFECT;
   logic [23:0] csr_data = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [3:0]  rsp_led_index;
   logic [7:0]  rsp_red, rsp_green, rsp_blue, rsp_brightness;
   logic        rsp_last;

   led_strip_effect_generator_top dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // predictor state
   logic [2:0]  fx_sel;
   logic [23:0] fx_color;
   logic [7:0]  fx_bright;
   logic [23:0] leds [10];
   bit          sticky_full;
   int unsigned dot_pos;
   logic [31:0] dot_t, strobe_t, sos_t, haz_t, pol_t;
   int unsigned strobe_cnt, sos_idx, pol_cnt;
   bit          strobe_on, sos_on, haz_on, pol_left, pol_on;

   led_item_t   expected_leds [$];
   int          errors = 0;
   int          cycles = 0;
   int          hold_left = 0;
   bit          no_idle = 0;

   function automatic logic [23:0] dim(input logic [23:0] c);
      logic [23:0] o;
      for (int k = 0; k < 3; k++) o[k*8 +: 8] = (c[k*8 +: 8] * 206) >> 8;
      return o;
   endfunction

   task automatic model_reset();
      fx_sel = 0; fx_color = 0; fx_bright = 255;
      foreach (leds[i]) leds[i] = 0;
      sticky_full = 0; dot_pos = 0; dot_t = 0; strobe_t = 0; strobe_cnt = 0;
      strobe_on = 0; sos_t = 0; sos_idx = 0; sos_on = 0; haz_t = 0; haz_on = 0;
      pol_t = 0; pol_cnt = 0; pol_left = 1; pol_on = 0;
   endtask

   function automatic bit predict_frame(input logic [31:0] now);
      logic [31:0] d, w;
      logic [23:0] c;
      bit wr;
      wr = 1;
      case (fx_sel)
         FX_DOT: begin
            if (now - dot_t <= DOT_WAIT) wr = 0;
            else begin
               dot_t = now;
               foreach (leds[i]) leds[i] = dim(leds[i]);
               leds[dot_pos] = fx_color;
               dot_pos = (dot_pos + 1) % 10;
            end
         end
         FX_STROBE: begin
            d = now - strobe_t;
            if (!strobe_on) begin
               if (d > STROBE_IDLE) begin
                  strobe_on = 1; strobe_cnt = 0;
               end
               foreach (leds[i]) leds[i] = COLOR_BLACK;
            end else if (d <= STROBE_STEP) wr = 0;
            else begin
               c = strobe_cnt[0] ? COLOR_BLACK : COLOR_WHITE;
               if (!strobe_cnt[0]) sticky_full = 1;
               foreach (leds[i]) leds[i] = c;
               strobe_cnt = (strobe_cnt + 1) & 31;
               strobe_t = now;
               if (strobe_cnt >= 18) strobe_on = 0;
            end
         end
         FX_SOS: begin
            w = sos_on ? sos_duration(sos_idx[3:0]) : SOS_DARK;
            if (now - sos_t < w) wr = 0;
            else begin
               sos_t = now; sos_on = !sos_on;
               foreach (leds[i]) leds[i] = sos_on ? COLOR_SOS : COLOR_BLACK;
               if (!sos_on) sos_idx = (sos_idx + 1) % 15;
            end
         end
         FX_HAZARD: begin
            if (now - haz_t <= HAZARD_WAIT) wr = 0;
            else begin
               haz_t = now; haz_on = !haz_on;
               c = haz_on ? COLOR_HAZARD : COLOR_BLACK;
               foreach (leds[i]) leds[i] = (i == 0 || i == 4 || i == 5 || i == 9) ? c : 0;
            end
         end
         FX_POLICE: begin
            w = (pol_cnt == 0 && !pol_on) ? POLICE_PAUSE : POLICE_BLINK;
            if (now - pol_t < w) wr = 0;
            else begin
               pol_t = now;
               foreach (leds[i]) leds[i] = COLOR_BLACK;
               if (pol_on) begin
                  foreach (leds[i])
                     if (pol_left && (i < 2 || i > 6)) leds[i] = COLOR_BLUE;
                     else if (!pol_left && i >= 2 && i <= 6) leds[i] = COLOR_RED;
                  pol_cnt = (pol_cnt + 1) & 3;
               end
               pol_on = !pol_on;
               if (!pol_on && pol_cnt >= 3) begin
                  pol_left = !pol_left; pol_cnt = 0;
               end
            end
         end
         default: foreach (leds[i]) leds[i] = fx_color;
      endcase
      return wr;
   endfunction

   task automatic queue_frame(input logic [31:0] now, input tick_row_t row);
      led_item_t e;
      if (!predict_frame(now)) return;
      for (int i = 0; i < 10; i++) begin
         e.idx = 4'(i); e.r = leds[i][23:16]; e.g = leds[i][15:8]; e.b = leds[i][7:0];
         e.bri = sticky_full ? 8'd255 : fx_bright;
         e.lst = (i == 9);
         if (row.known) begin
            e.r = row.rgb[23:16]; e.g = row.rgb[15:8]; e.b = row.rgb[7:0]; e.bri = row.bri;
         end
         expected_leds.push_back(e);
      end
   endtask

   task automatic send_tick(input logic [31:0] now, input tick_row_t row);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1; req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      queue_frame(now, row);
   endtask

   task automatic tick(input logic [31:0] now);
      tick_row_t row;
      row.now = now; row.known = 0; row.rgb = 0; row.bri = 0;
      send_tick(now, row);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_leds.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [23:0] val);
      csr_write <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_EFFECT:     fx_sel = val[2:0];
         CSR_COLOR:      fx_color = val;
         CSR_BRIGHTNESS: fx_bright = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // result side: random stalls and checking
   always @(posedge clock) begin
      led_item_t got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_led_index, rsp_red, rsp_green, rsp_blue, rsp_brightness, rsp_last};
         if (expected_leds.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected led item %p", got);
         end else begin
            want = expected_leds.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (!no_idle && $urandom_range(0, 12) == 0) hold_left <= $urandom_range(1, 16);
      rsp_ready <= !reset && (no_idle || hold_left == 0);
   end

   always @(posedge clock)
      if (cycles > 400000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end

   tick_row_t dir_rows [$];
   logic [31:0] t;
   logic [2:0] fx_list [8] = '{3'd0, FX_DOT, 3'd2, FX_STROBE, FX_SOS, FX_HAZARD, FX_POLICE, 3'd7};

   initial begin
      model_reset();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // after reset: static black at 255, then color/brightness extremes
      dir_rows.push_back('{32'd0, 1, 24'h000000, 8'd255});
      dir_rows.push_back('{32'hFFFFFFFF, 1, 24'h000000, 8'd255});
      foreach (dir_rows[i]) send_tick(dir_rows[i].now, dir_rows[i]);
      drain();
      write_reg(CSR_COLOR, 24'hFFFFFF); write_reg(CSR_BRIGHTNESS, 24'h0);
      tick(32'd1);
      drain();
      write_reg(csr_index_type'(2'd3), 24'h5); // unknown index, ignored
      write_reg(CSR_COLOR, 24'hA5C3F0); write_reg(CSR_BRIGHTNESS, 24'h80);
      // every effect briefly, including unused codes
      t = 0;
      foreach (fx_list[k]) begin
         drain();
         write_reg(CSR_EFFECT, 24'(fx_list[k]));
         repeat (3) begin
            t += 320; tick(t);
         end
      end
      // random phases: well-formed time progress, sometimes wraps and jumps
      t = 32'hFFFF_F000;
      for (int ph = 0; ph < 7; ph++) begin
         drain();
         write_reg(CSR_EFFECT, (ph == 0) ? 24'(FX_STROBE) : 24'($urandom_range(0, 7)));
         write_reg(CSR_COLOR, 24'($urandom));
         write_reg(CSR_BRIGHTNESS, (ph == 6) ? 24'hFF : 24'($urandom_range(0, 255)));
         if (ph == 6) no_idle = 1;
         for (int n = 0; n < 26; n++) begin
            if ($urandom_range(0, 15) == 0) t = $urandom;
            else if (ph == 0) t += $urandom_range(40, 5200);
            else t += $urandom_range(0, 700);
            tick(t);
         end
      end
      drain();
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> sim.f
sv/lse_pkg.sv
sv/lse_front.sv
sv/lse_queue.sv
sv/lse_back.sv
sv/led_strip_effect_generator_top.sv
tb/tb_led_strip_effect_generator_top.sv
